// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the resolver RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define ARPR_ASSERT(lbl, ck, rs, prp, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prp) else $error(msg);

// Clocked check that also holds across reset.
`define ARPR_ASSERT_ALWAYS(lbl, ck, prp, msg) \
  lbl: assert property (@(posedge ck) prp) else $error(msg);

`endif

// ===== rtl/arpr_pkg.sv =====
// Shared types and constants of the ARP address resolver.
// No dependencies; imported by every resolver module.
package arpr_pkg;

  // Frame acceptance limits
  localparam logic [7:0]  MAX_FRAMES      = 8'd64;
  localparam logic [10:0] MIN_FRAME_BYTES = 11'd42;
  localparam logic [15:0] ETYPE_ARP       = 16'h0806;
  localparam logic [15:0] OP_REPLY        = 16'd2;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;

  // Stream widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 168;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

  typedef enum logic [1:0] {
    ACT_RESOLVE  = 2'd0,
    ACT_FRAME    = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_LINK_ERR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNREACH = 2'd1,
    ST_LINK    = 2'd2,
    ST_BUSY    = 2'd3
  } status_t;

  typedef enum logic {
    KIND_REQUEST = 1'b0,
    KIND_ANSWER  = 1'b1
  } kind_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] query_ip;
    logic [10:0] frame_length;
    logic [15:0] frame_ethertype;
    logic [15:0] frame_opcode;
    logic [31:0] frame_sender_ip;
    logic [47:0] frame_sender_mac;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [47:0] resolved_mac;
    logic [31:0] request_target_ip;
    logic [47:0] request_sender_mac;
    logic [31:0] request_sender_ip;
  } result_t;

  // Core status seen by the top level
  typedef struct packed {
    logic        waiting;
    logic [15:0] ticks_left;
  } core_stat_t;

endpackage

// ===== rtl/arp_address_resolver.sv =====
// ARP address resolver with a one-entry cache.
// Input stream (s_axis_*): one beat per event; tuser carries the action
// (resolve, received frame, timer tick, link error), tdata the query IP
// and the parsed header fields of a received frame.
// Output stream (m_axis_*): zero or one beat per input beat; tuser is the
// kind (ARP request to transmit, or resolution answer), tdata the status,
// resolved MAC and request fields.
// Config channel (cfg_*): register index and data, always ready. The user
// must see that it is written only while the block is idle; the block does not enforce this.
// A result beat is presented on m_axis after its input beat passes the input
// register and then the result register.
// Throughput: one beat per cycle while the receiver does not stall; the wait
// state and cache update as an item leaves the input register.
// Reset clears the wait state, the cache and both stage valids; the
// timeout register returns to 1000 ticks.
// When the receiver stalls, the result register holds, the input register
// fills with one more beat and then s_axis_tready drops.
// Depends on arpr_pkg, assert_macros.svh, arpr_in_stage, arpr_core and arpr_out_stage.
module arp_address_resolver (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // query_ip[31:0], frame_length[42:32], frame_ethertype[58:43],
  // frame_opcode[74:59], frame_sender_ip[106:75],
  // frame_sender_mac[154:107], zero pad
  input  logic [arpr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // action[1:0]
  input  logic [arpr_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status[1:0], resolved_mac[49:2], request_target_ip[81:50],
  // request_sender_mac[129:82], request_sender_ip[161:130], zero pad
  output logic [arpr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // kind[0]
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [arpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [arpr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import arpr_pkg::*;

  logic       item_vld;
  item_t      item;
  logic       go;
  logic       res_vld;
  result_t    res;
  core_stat_t core_stat;
  logic       out_free;

  assign cfg_ready = 1'b1;

  // Item moves on when the result register can take its beat
  assign go = item_vld && out_free;

  arpr_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take          (go),
    .item_vld      (item_vld),
    .item          (item)
  );

  arpr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_vld  (item_vld),
    .item      (item),
    .go        (go),
    .res_vld   (res_vld),
    .res       (res),
    .stat      (core_stat)
  );

  arpr_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (go && res_vld),
    .res           (res),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Checks
  `include "assert_macros.svh"

  `ARPR_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_axis_tvalid && !core_stat.waiting, "reset did not idle the block")
  `ARPR_ASSERT(a_stall_blocks_input, clk, rst, item_vld && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while both stages full")
  `ARPR_ASSERT(a_request_starts_wait, clk, rst, go && res_vld && res.kind == KIND_REQUEST |=> core_stat.waiting, "request sent without entering wait")
  `ARPR_ASSERT(a_wait_has_ticks, clk, rst, core_stat.waiting |-> core_stat.ticks_left != 16'd0, "waiting with no ticks left")

endmodule

// ===== rtl/arpr_in_stage.sv =====
// Input register of the resolver: captures one stream beat and unpacks it.
// Depends on arpr_pkg.
module arpr_in_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // query_ip, frame_length, frame_ethertype, frame_opcode,
  // frame_sender_ip, frame_sender_mac, zero pad
  input  logic [arpr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // action
  input  logic [arpr_pkg::IN_USER_W-1:0]    s_axis_tuser,
  input  logic                              take,
  output logic                              item_vld,
  output arpr_pkg::item_t                   item
);
  import arpr_pkg::*;

  // Register is free when empty or drained this cycle
  assign s_axis_tready = !item_vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (s_axis_tready) begin
      item_vld <= s_axis_tvalid;
    end
  end

  // Payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item.action           <= action_t'(s_axis_tuser);
      item.query_ip         <= s_axis_tdata[31:0];
      item.frame_length     <= s_axis_tdata[42:32];
      item.frame_ethertype  <= s_axis_tdata[58:43];
      item.frame_opcode     <= s_axis_tdata[74:59];
      item.frame_sender_ip  <= s_axis_tdata[106:75];
      item.frame_sender_mac <= s_axis_tdata[154:107];
    end
  end

endmodule

// ===== rtl/arpr_core.sv =====
// Resolver core: config registers, wait state, one-entry cache and the
// single-pass decision logic. Depends on arpr_pkg.
module arpr_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [arpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [arpr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               item_vld,
  input  arpr_pkg::item_t                    item,
  input  logic                               go,
  output logic                               res_vld,
  output arpr_pkg::result_t                  res,
  output arpr_pkg::core_stat_t               stat
);
  import arpr_pkg::*;

  logic [31:0] local_ip;
  logic [47:0] local_mac;
  logic [15:0] timeout_ticks;

  logic        waiting,    waiting_next;
  logic [31:0] pending_ip, pending_ip_next;
  logic [15:0] ticks_left, ticks_left_next;
  logic [7:0]  frames_seen, frames_seen_next;
  logic [31:0] cache_ip,   cache_ip_next;
  logic [47:0] cache_mac,  cache_mac_next;

  logic        has_res;
  logic [7:0]  frames_inc;
  logic        cache_hit;
  logic        reply_match;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip      <= '0;
      local_mac     <= '0;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOCAL_IP:  local_ip      <= cfg_data[31:0];
        CFG_LOCAL_MAC: local_mac     <= cfg_data[47:0];
        CFG_TIMEOUT:   timeout_ticks <= cfg_data[15:0];
        default:       ;
      endcase
    end
  end

  assign frames_inc  = frames_seen + 8'd1;
  assign cache_hit   = (cache_ip != '0) && (cache_ip == item.query_ip);
  assign reply_match = (item.frame_length >= MIN_FRAME_BYTES) &&
                       (item.frame_ethertype == ETYPE_ARP) &&
                       (item.frame_opcode == OP_REPLY) &&
                       (item.frame_sender_ip == pending_ip);

  // Decision logic for the item in the input register
  always_comb begin
    has_res          = 1'b0;
    res              = '0;
    waiting_next     = waiting;
    pending_ip_next  = pending_ip;
    ticks_left_next  = ticks_left;
    frames_seen_next = frames_seen;
    cache_ip_next    = cache_ip;
    cache_mac_next   = cache_mac;
    unique case (item.action)
      ACT_RESOLVE: begin
        has_res = 1'b1;
        if (waiting) begin
          res.kind   = KIND_ANSWER;
          res.status = ST_BUSY;
        end else if (cache_hit) begin
          res.kind         = KIND_ANSWER;
          res.status       = ST_OK;
          res.resolved_mac = cache_mac;
        end else begin
          waiting_next           = 1'b1;
          pending_ip_next        = item.query_ip;
          ticks_left_next        = (timeout_ticks != '0) ? timeout_ticks : 16'd1;
          frames_seen_next       = '0;
          res.kind               = KIND_REQUEST;
          res.status             = ST_OK;
          res.request_target_ip  = item.query_ip;
          res.request_sender_mac = local_mac;
          res.request_sender_ip  = local_ip;
        end
      end
      ACT_FRAME: begin
        if (waiting) begin
          if (reply_match) begin
            has_res          = 1'b1;
            cache_ip_next    = pending_ip;
            cache_mac_next   = item.frame_sender_mac;
            waiting_next     = 1'b0;
            res.kind         = KIND_ANSWER;
            res.status       = ST_OK;
            res.resolved_mac = item.frame_sender_mac;
          end else begin
            frames_seen_next = frames_inc;
            if (frames_inc >= MAX_FRAMES) begin
              has_res      = 1'b1;
              waiting_next = 1'b0;
              res.kind     = KIND_ANSWER;
              res.status   = ST_UNREACH;
            end
          end
        end
      end
      ACT_TICK: begin
        if (waiting) begin
          if (ticks_left > 16'd1) begin
            ticks_left_next = ticks_left - 16'd1;
          end else begin
            has_res         = 1'b1;
            ticks_left_next = '0;
            waiting_next    = 1'b0;
            res.kind        = KIND_ANSWER;
            res.status      = ST_UNREACH;
          end
        end
      end
      ACT_LINK_ERR: begin
        if (waiting) begin
          has_res      = 1'b1;
          waiting_next = 1'b0;
          res.kind     = KIND_ANSWER;
          res.status   = ST_LINK;
        end
      end
      default: ;
    endcase
  end

  assign res_vld = item_vld && has_res;

  // State update when the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      waiting     <= 1'b0;
      pending_ip  <= '0;
      ticks_left  <= '0;
      frames_seen <= '0;
      cache_ip    <= '0;
      cache_mac   <= '0;
    end else if (go) begin
      waiting     <= waiting_next;
      pending_ip  <= pending_ip_next;
      ticks_left  <= ticks_left_next;
      frames_seen <= frames_seen_next;
      cache_ip    <= cache_ip_next;
      cache_mac   <= cache_mac_next;
    end
  end

  assign stat.waiting    = waiting;
  assign stat.ticks_left = ticks_left;

endmodule

// ===== rtl/arpr_out_stage.sv =====
// Output register of the resolver: holds one result beat for the receiver.
// Depends on arpr_pkg.
module arpr_out_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  arpr_pkg::result_t                 res,
  output logic                              out_free,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status, resolved_mac, request_target_ip, request_sender_mac,
  // request_sender_ip, zero pad
  output logic [arpr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // kind
  output logic                              m_axis_tuser
);
  import arpr_pkg::*;

  // Free when empty or being taken this cycle
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= load;
    end
  end

  // Pack the result beat
  always_ff @(posedge clk) begin
    if (load && out_free) begin
      m_axis_tuser          <= res.kind;
      m_axis_tdata[1:0]     <= res.status;
      m_axis_tdata[49:2]    <= res.resolved_mac;
      m_axis_tdata[81:50]   <= res.request_target_ip;
      m_axis_tdata[129:82]  <= res.request_sender_mac;
      m_axis_tdata[161:130] <= res.request_sender_ip;
      m_axis_tdata[167:162] <= '0;
    end
  end

endmodule
